/* sv/fpr_pkg.sv */
package fpr_pkg;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SECOND,
		PH_HEADER,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_TICK,
		CMD_READ,
		CMD_NOP
	} cmd_t;

	localparam logic [1:0] KIND_PACKET = 2'd0;
	localparam logic [1:0] KIND_ERROR  = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	localparam logic [1:0] ERR_VERSION = 2'd0;
	localparam logic [1:0] ERR_LENGTH  = 2'd1;
	localparam logic [1:0] ERR_CRC     = 2'd2;
	localparam logic [1:0] ERR_TIMEOUT = 2'd3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_START_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERSION      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd4;

	localparam int LEN_W  = 11;
	localparam int IDLE_W = 24;

	localparam logic [15:0]       CRC_POLY = 16'h1021;
	localparam logic [15:0]       CRC_SEED = 16'hFFFF;
	localparam logic [IDLE_W-1:0] IDLE_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic [7:0]        start_first;
		logic [7:0]        start_second;
		logic [7:0]        version;
		logic [LEN_W-1:0]  limit;
		logic [IDLE_W-1:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [1:0]       kind;
		logic [1:0]       error_code;
		logic [7:0]       packet_type;
		logic [7:0]       packet_flags;
		logic [15:0]      sequence_res;
		logic [LEN_W-1:0] payload_length;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* sv/fpr_req_if.sv */
interface fpr_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;
	logic [9:0] read_index;

	modport source(output valid, output command, output data_byte, output read_index,
		input ready);
	modport sink(input valid, input command, input data_byte, input read_index,
		output ready);
endinterface

/* sv/fpr_res_if.sv */
interface fpr_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  error_code;
	logic [7:0]  packet_type;
	logic [7:0]  packet_flags;
	logic [15:0] sequence_res;
	logic [10:0] payload_length;
	logic [7:0]  read_data;

	modport source(output valid, output kind, output error_code, output packet_type,
		output packet_flags, output sequence_res, output payload_length, output read_data,
		input ready);
	modport sink(input valid, input kind, input error_code, input packet_type,
		input packet_flags, input sequence_res, input payload_length, input read_data,
		output ready);
endinterface

/* sv/fpr_cfg_if.sv */
interface fpr_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* sv/fpr_ram.sv */
module fpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/fpr_parser.sv */
module fpr_parser #(
	parameter int PAYLOAD_DEPTH = 1024,
	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [1:0]       command,
	input  logic [7:0]       data_byte,
	input  fpr_pkg::cfg_t    cfg,
	output logic             we,
	output logic [AW-1:0]    waddr,
	output logic [7:0]       wdata,
	output fpr_pkg::result_t result
);
	import fpr_pkg::*;

	phase_t            phase_q, phase_d;
	cmd_t              cmd;
	logic [2:0]        hdr_cnt_q;
	logic [7:0]        hdr_q [8];
	logic [LEN_W-1:0]  pay_cnt_q;
	logic [LEN_W-1:0]  pay_next;
	logic [LEN_W-1:0]  len_q;
	logic              chk_cnt_q;
	logic [7:0]        chk_lo_q;
	logic [15:0]       crc_q;
	logic [15:0]       crc_nx;
	logic [IDLE_W-1:0] idle_q;
	logic [IDLE_W-1:0] idle_inc;
	logic [15:0]       len16;
	logic              bad_ver;
	logic              bad_len;
	logic              hdr_last;
	logic              pay_done;
	logic              timeout_hit;
	logic              is_byte;

	assign cmd      = cmd_t'(command);
	assign is_byte  = fire && (cmd == CMD_BYTE);
	assign crc_nx   = crc_byte(crc_q, data_byte);
	assign len16    = {data_byte, hdr_q[6]};
	assign hdr_last = (hdr_cnt_q == 3'd7);
	assign bad_ver  = (hdr_q[0] != cfg.version);
	assign bad_len  = (17'(len16) > 17'(cfg.limit)) || (17'(len16) > 17'(PAYLOAD_DEPTH));
	assign pay_next = pay_cnt_q + LEN_W'(1);
	assign pay_done = (pay_next >= len_q);
	assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + IDLE_W'(1);
	assign timeout_hit = (cfg.timeout != '0) && (phase_q != PH_FIRST)
		&& (idle_inc >= cfg.timeout);

	assign we    = is_byte && (phase_q == PH_PAYLOAD)
		&& (17'(pay_cnt_q) < 17'(PAYLOAD_DEPTH));
	assign waddr = AW'(pay_cnt_q);
	assign wdata = data_byte;

	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			if (cmd == CMD_BYTE) begin
				unique case (phase_q)
					PH_FIRST: begin
						if (data_byte == cfg.start_first) begin
							phase_d = PH_SECOND;
						end
					end
					PH_SECOND: begin
						if (data_byte == cfg.start_second) begin
							phase_d = PH_HEADER;
						end else if (data_byte != cfg.start_first) begin
							phase_d = PH_FIRST;
						end
					end
					PH_HEADER: begin
						if (hdr_last) begin
							if (bad_ver || bad_len) begin
								phase_d = PH_FIRST;
							end else if (len16 == 16'd0) begin
								phase_d = PH_CHECK;
							end else begin
								phase_d = PH_PAYLOAD;
							end
						end
					end
					PH_PAYLOAD: begin
						if (pay_done) begin
							phase_d = PH_CHECK;
						end
					end
					PH_CHECK: begin
						if (chk_cnt_q) begin
							phase_d = PH_FIRST;
						end
					end
					default: phase_d = PH_FIRST;
				endcase
			end else if (cmd == CMD_TICK && timeout_hit) begin
				phase_d = PH_FIRST;
			end
		end
	end

	always_comb begin
		result = '0;
		if (fire) begin
			unique case (cmd)
				CMD_BYTE: begin
					if (phase_q == PH_HEADER && hdr_last) begin
						if (bad_ver) begin
							result.valid      = 1'b1;
							result.kind       = KIND_ERROR;
							result.error_code = ERR_VERSION;
						end else if (bad_len) begin
							result.valid      = 1'b1;
							result.kind       = KIND_ERROR;
							result.error_code = ERR_LENGTH;
						end
					end else if (phase_q == PH_CHECK && chk_cnt_q) begin
						result.valid = 1'b1;
						if ({data_byte, chk_lo_q} != crc_q) begin
							result.kind       = KIND_ERROR;
							result.error_code = ERR_CRC;
						end else begin
							result.kind           = KIND_PACKET;
							result.packet_type    = hdr_q[1];
							result.packet_flags   = hdr_q[2];
							result.sequence_res   = {hdr_q[5], hdr_q[4]};
							result.payload_length = len_q;
						end
					end
				end
				CMD_TICK: begin
					if (timeout_hit) begin
						result.valid      = 1'b1;
						result.kind       = KIND_ERROR;
						result.error_code = ERR_TIMEOUT;
					end
				end
				CMD_READ: begin
					result.valid = 1'b1;
					result.kind  = KIND_READ;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_byte && phase_q == PH_HEADER) begin
			hdr_q[hdr_cnt_q] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FIRST;
			hdr_cnt_q <= '0;
			pay_cnt_q <= '0;
			len_q     <= '0;
			chk_cnt_q <= 1'b0;
			chk_lo_q  <= '0;
			crc_q     <= CRC_SEED;
			idle_q    <= '0;
		end else begin
			phase_q <= phase_d;
			if (fire) begin
				case (cmd)
					CMD_BYTE: begin
						idle_q <= '0;
						case (phase_q)
							PH_SECOND: begin
								if (data_byte == cfg.start_second) begin
									hdr_cnt_q <= '0;
									crc_q     <= CRC_SEED;
								end
							end
							PH_HEADER: begin
								hdr_cnt_q <= hdr_cnt_q + 3'd1;
								crc_q     <= crc_nx;
								if (hdr_last) begin
									len_q     <= len16[LEN_W-1:0];
									pay_cnt_q <= '0;
									chk_cnt_q <= 1'b0;
								end
							end
							PH_PAYLOAD: begin
								pay_cnt_q <= pay_next;
								crc_q     <= crc_nx;
							end
							PH_CHECK: begin
								if (!chk_cnt_q) begin
									chk_lo_q  <= data_byte;
									chk_cnt_q <= 1'b1;
								end else begin
									chk_cnt_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
					CMD_TICK: idle_q <= timeout_hit ? '0 : idle_inc;
					default: ;
				endcase
			end
		end
	end

endmodule

/* sv/framed_uart_packet_receiver_core.sv */
// channel | dir | handshake        | payload
// req     | in  | valid/ready      | command, data_byte, read_index
// res     | out | valid/ready      | kind, error_code, packet_type, packet_flags,
//         |     |                  | sequence_res, payload_length, read_data
// cfg     | in  | valid/ready (=1) | index, data
//
// One transaction per cycle on req while req.ready is high; each result leaves
// through a parse register stage and then the output register.
// The payload buffer is a single-port-write, registered-read RAM; reads and
// writes come from different transactions and never share a cycle.
// Reset clears the parser and the output side; buffer contents stay undefined.
// A stalled res holds its data and backs up into req once one more result waits.
module framed_uart_packet_receiver_core #(
	parameter int PAYLOAD_DEPTH = 1024
) (
	input logic    clk,
	input logic    arst_n,
	fpr_req_if.sink   req,
	fpr_res_if.source res,
	fpr_cfg_if.sink   cfg
);
	import fpr_pkg::*;

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	cfg_t          cfg_q;
	result_t       result;
	result_t       s1_res_s1;
	result_t       res_q;
	logic          s1_valid_s1;
	logic          s1_inrange_s1;
	logic          res_valid_q;
	logic [7:0]    read_data_q;
	logic          fire;
	logic          adv;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic [16:0]   idx_ext;
	logic          idx_inrange;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_first  <= 8'hA5;
			cfg_q.start_second <= 8'h5A;
			cfg_q.version      <= 8'h01;
			cfg_q.limit        <= 11'd1024;
			cfg_q.timeout      <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_START_FIRST:  cfg_q.start_first  <= cfg.data[7:0];
				REG_START_SECOND: cfg_q.start_second <= cfg.data[7:0];
				REG_VERSION:      cfg_q.version      <= cfg.data[7:0];
				REG_LIMIT:        cfg_q.limit        <= cfg.data[LEN_W-1:0];
				REG_TIMEOUT:      cfg_q.timeout      <= cfg.data[IDLE_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv       = !res_valid_q || res.ready;
	assign req.ready = !s1_valid_s1 || adv;
	assign fire      = req.valid && req.ready;

	assign idx_ext     = 17'(req.read_index);
	assign idx_inrange = idx_ext < 17'(PAYLOAD_DEPTH);
	assign ram_re      = fire && (req.command == CMD_READ);
	assign ram_raddr   = idx_ext[AW-1:0];

	fpr_parser #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.command   (req.command),
		.data_byte (req.data_byte),
		.cfg       (cfg_q),
		.we        (ram_we),
		.waddr     (ram_waddr),
		.wdata     (ram_wdata),
		.result    (result)
	);

	fpr_ram #(.WIDTH(8), .DEPTH(PAYLOAD_DEPTH)) u_payload_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				s1_valid_s1 <= result.valid;
			end else if (adv) begin
				s1_valid_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_q <= s1_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			s1_res_s1     <= result;
			s1_inrange_s1 <= idx_inrange;
		end
		if (adv && s1_valid_s1) begin
			res_q <= s1_res_s1;
			if (s1_res_s1.kind == KIND_READ && s1_inrange_s1) begin
				read_data_q <= ram_rdata;
			end else begin
				read_data_q <= '0;
			end
		end
	end

	assign res.valid          = res_valid_q;
	assign res.kind           = res_q.kind;
	assign res.error_code     = res_q.error_code;
	assign res.packet_type    = res_q.packet_type;
	assign res.packet_flags   = res_q.packet_flags;
	assign res.sequence_res   = res_q.sequence_res;
	assign res.payload_length = res_q.payload_length;
	assign res.read_data      = read_data_q;

	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !adv) |-> !req.ready)
		else $error("req accepted while parse stage is stalled");

	a_drain_empties_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !s1_valid_s1) |=> !res_valid_q)
		else $error("output register loaded without a parsed result");

	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req.command == CMD_READ) |=> (s1_valid_s1 && s1_res_s1.kind == KIND_READ))
		else $error("read transaction did not produce a read result");

endmodule
